// File: hdl/h264sps_pkg.sv
// ----------------------------------------------------------------------------
// h264sps_pkg
// Shared types, constants and tables of the SPS header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package h264sps_pkg;

  localparam int unsigned VAL_W      = 33;
  localparam int unsigned LOOP_W     = 33;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned LZ_W       = 6;
  localparam int unsigned LZ_MAX     = 32;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0]  EPB_CODE     = 8'h03;
  localparam logic [7:0]  PROFILE_HIGH = 8'd100;
  localparam int unsigned SAR_ESCAPE   = 255;
  localparam int unsigned SAR_ENTRIES  = 17;
  localparam int unsigned REORDER_MAX  = 16;
  localparam int unsigned FNUM_MAX     = 12;
  localparam int unsigned POCT_MAX     = 255;
  localparam int unsigned SIZE_SAT_V   = 4095;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_SPS_ID  = 2'd1;
  localparam logic [1:0] STAT_REORDER = 2'd2;

  localparam int unsigned FL_MBS_ONLY = 0;
  localparam int unsigned FL_CROP     = 1;
  localparam int unsigned FL_VUI      = 2;
  localparam int unsigned FL_TIMING   = 3;
  localparam int unsigned FL_FIXED    = 4;
  localparam int unsigned FL_BYPASS   = 5;
  localparam int unsigned FL_RESTRICT = 6;

  typedef enum logic [5:0] {
    ST_PROFILE, ST_SKIP16, ST_SPSID, ST_CHROMA, ST_RESID, ST_DEPTHL, ST_DEPTHC,
    ST_BYPASS, ST_SCALING, ST_FRAMENUM, ST_POCTYPE, ST_POCLSB, ST_DELTAZERO,
    ST_OFFNONREF, ST_OFFTB, ST_CYCLE, ST_CYCLEOFF, ST_NUMREF, ST_GAPS,
    ST_WIDTH, ST_HEIGHT, ST_MBSONLY, ST_MBAFF, ST_DIRECT, ST_CROP, ST_CROPVAL,
    ST_VUI, ST_ASPFLAG, ST_ASPIDC, ST_SARNUM, ST_SARDEN, ST_OVERSCAN,
    ST_OVERAPP, ST_VIDSIG, ST_VIDFMT, ST_COLDESC, ST_COLOURS, ST_CHROMALOC,
    ST_CHROMALOCVAL, ST_TIMING, ST_TICK, ST_SCALE, ST_FIXED, ST_NALHRD,
    ST_CPBCNT, ST_SCALES, ST_BRV, ST_CPBV, ST_CBR, ST_DELAYS, ST_VCLHRD,
    ST_LOWDELAY, ST_PICSTRUCT, ST_RESTRICT, ST_MVBOUND, ST_RESTRVAL,
    ST_REORDER, ST_DONE
  } step_e;

  typedef enum logic [1:0] {RD_FIXED, RD_PREFIX, RD_SUFFIX} rd_e;

  typedef enum logic [1:0] {BK_IDLE, BK_BITS, BK_DRAIN} bk_state_e;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_st_t;

  // Width of a fixed read; zero marks an exp-Golomb read.
  function automatic logic [5:0] step_bits(step_e s);
    logic [5:0] n;
    n = 6'd0;
    unique case (s)
      ST_PROFILE, ST_ASPIDC, ST_SCALES: n = 6'd8;
      ST_SKIP16, ST_SARNUM, ST_SARDEN: n = 6'd16;
      ST_RESID, ST_BYPASS, ST_SCALING, ST_DELTAZERO, ST_GAPS, ST_MBSONLY,
      ST_MBAFF, ST_DIRECT, ST_CROP, ST_VUI, ST_ASPFLAG, ST_OVERSCAN,
      ST_OVERAPP, ST_VIDSIG, ST_COLDESC, ST_CHROMALOC, ST_TIMING, ST_FIXED,
      ST_NALHRD, ST_CBR, ST_VCLHRD, ST_LOWDELAY, ST_PICSTRUCT, ST_RESTRICT,
      ST_MVBOUND: n = 6'd1;
      ST_VIDFMT: n = 6'd4;
      ST_COLOURS: n = 6'd24;
      ST_TICK, ST_SCALE: n = 6'd32;
      ST_DELAYS: n = 6'd20;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] sar_num(logic [4:0] idx);
    logic [7:0] r;
    r = 8'd0;
    unique case (idx)
      5'd1: r = 8'd1;    5'd2: r = 8'd12;  5'd3: r = 8'd10;  5'd4: r = 8'd16;
      5'd5: r = 8'd40;   5'd6: r = 8'd24;  5'd7: r = 8'd20;  5'd8: r = 8'd32;
      5'd9: r = 8'd80;   5'd10: r = 8'd18; 5'd11: r = 8'd15; 5'd12: r = 8'd64;
      5'd13: r = 8'd160; 5'd14: r = 8'd4;  5'd15: r = 8'd3;  5'd16: r = 8'd2;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sar_den(logic [4:0] idx);
    logic [7:0] r;
    r = 8'd0;
    unique case (idx)
      5'd1: r = 8'd1;
      5'd2, 5'd3, 5'd4, 5'd6, 5'd7, 5'd8, 5'd10, 5'd11: r = 8'd11;
      5'd5, 5'd9, 5'd12: r = 8'd33;
      5'd13: r = 8'd99;
      5'd14: r = 8'd3;
      5'd15: r = 8'd2;
      5'd16: r = 8'd1;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/h264sps_in_if.sv
// ----------------------------------------------------------------------------
// h264sps_in_if
// Payload byte channel with a final-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface h264sps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_last;

  modport source (output valid, output payload_byte, output is_last, input ready);
  modport sink (input valid, input payload_byte, input is_last, output ready);
endinterface

`default_nettype wire

// File: hdl/h264sps_out_if.sv
// ----------------------------------------------------------------------------
// h264sps_out_if
// Parse result channel, one transaction for each parameter set.
// ----------------------------------------------------------------------------
`default_nettype none

interface h264sps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  parse_status;
  logic [7:0]  profile_code;
  logic [6:0]  flag_bits;
  logic [15:0] width_pixels;
  logic [15:0] height_pixels;
  logic [3:0]  frame_num_log2;
  logic [7:0]  order_count_type;
  logic [15:0] aspect_num;
  logic [15:0] aspect_den;
  logic [31:0] tick_units;
  logic [31:0] clock_scale;
  logic [4:0]  reorder_frames;

  modport source (
    output valid, output parse_status, output profile_code, output flag_bits,
    output width_pixels, output height_pixels, output frame_num_log2,
    output order_count_type, output aspect_num, output aspect_den,
    output tick_units, output clock_scale, output reorder_frames, input ready
  );
  modport sink (
    input valid, input parse_status, input profile_code, input flag_bits,
    input width_pixels, input height_pixels, input frame_num_log2,
    input order_count_type, input aspect_num, input aspect_den,
    input tick_units, input clock_scale, input reorder_frames, output ready
  );
endinterface

`default_nettype wire

// File: hdl/h264sps_front.sv
// ----------------------------------------------------------------------------
// h264sps_front
// Accepts payload bytes and removes emulation-prevention bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module h264sps_front
  import h264sps_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  h264sps_in_if.sink  sps_in,
  input  wire logic   full_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic [1:0] zero_run_q, zero_run_d;
  logic       accept;
  logic       drop;

  assign sps_in.ready = !full_i;
  assign accept = sps_in.valid && !full_i;
  assign drop = (zero_run_q == 2'd2) && (sps_in.payload_byte == EPB_CODE) && !sps_in.is_last;
  assign push_o = accept && !drop;
  assign entry_o.last = sps_in.is_last;
  assign entry_o.data = sps_in.payload_byte;

  always_comb begin
    zero_run_d = zero_run_q;
    if (accept) begin
      if (drop || sps_in.is_last || (sps_in.payload_byte != 8'd0)) begin
        zero_run_d = 2'd0;
      end else if (zero_run_q != 2'd2) begin
        zero_run_d = zero_run_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= 2'd0;
    end else begin
      zero_run_q <= zero_run_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/h264sps_fifo.sv
// ----------------------------------------------------------------------------
// h264sps_fifo
// Short byte queue between the front and the bit parser.
// ----------------------------------------------------------------------------
`default_nettype none

module h264sps_fifo
  import h264sps_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  entry_t    entry_i,
  input  wire logic pop_i,
  output entry_t    entry_o,
  output fifo_st_t  status_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  entry_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(FIFO_DEPTH));
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/h264sps_back.sv
// ----------------------------------------------------------------------------
// h264sps_back
// Bit-serial walk of the SPS syntax and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module h264sps_back
  import h264sps_pkg::*;
#(
  parameter int unsigned MAX_POC_CYCLE = 256,
  parameter int unsigned MAX_SPS_ID    = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  entry_t        entry_i,
  input  fifo_st_t      fifo_st_i,
  output logic          pop_o,
  h264sps_out_if.source res_out
);

  bk_state_e          state_q, state_d;
  logic [2:0]         bitcnt_q, bitcnt_d;
  entry_t             cur_q, cur_d;
  step_e              step_q, step_d;
  rd_e                mode_q, mode_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [5:0]         bw_q, bw_d;
  logic [LZ_W-1:0]    lz_q, lz_d;
  logic [LOOP_W-1:0]  loop_q, loop_d;
  logic [1:0]         hrd_q, hrd_d;

  logic [1:0]  status_q, status_d;
  logic [7:0]  profile_q, profile_d;
  logic [6:0]  flags_q, flags_d;
  logic [15:0] width_q, width_d, height_q, height_d;
  logic [3:0]  fnum_q, fnum_d;
  logic [7:0]  poct_q, poct_d;
  logic [15:0] sarn_q, sarn_d, sard_q, sard_d;
  logic [31:0] tick_q, tick_d, scale_q, scale_d;
  logic [4:0]  reorder_q, reorder_d;

  logic        out_valid_q;
  logic        slot_free;
  logic        do_feed, do_drain, do_emit;
  logic        bit_v, final_bit;
  logic [VAL_W-1:0]  base, fin_v;
  logic [LOOP_W-1:0] loop_in, loop_dec;
  logic [ACC_W-1:0]  acc_nx;
  logic [5:0]        bw_nx, nbits;
  logic              fin_en;
  step_e             nxt;

  assign slot_free = !out_valid_q || res_out.ready;
  assign bit_v     = cur_q.data[bitcnt_q];
  assign final_bit = cur_q.last && (bitcnt_q == 3'd0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!fifo_st_i.empty) state_d = BK_BITS;
      end
      BK_BITS: begin
        if (bitcnt_q == 3'd0) begin
          if (cur_q.last) state_d = BK_DRAIN;
          else if (fifo_st_i.empty) state_d = BK_IDLE;
        end
      end
      BK_DRAIN: begin
        if (step_q == ST_DONE && slot_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    do_feed  = 1'b0;
    do_drain = 1'b0;
    do_emit  = 1'b0;
    unique case (state_q)
      BK_IDLE: pop_o = !fifo_st_i.empty;
      BK_BITS: begin
        do_feed = 1'b1;
        pop_o   = (bitcnt_q == 3'd0) && !cur_q.last && !fifo_st_i.empty;
      end
      BK_DRAIN: begin
        if (step_q == ST_DONE) do_emit = slot_free;
        else do_drain = 1'b1;
      end
      default: pop_o = 1'b0;
    endcase
  end

  always_comb begin
    bitcnt_d = do_feed ? bitcnt_q - 3'd1 : bitcnt_q;
    cur_d    = cur_q;
    if (pop_o) begin
      cur_d    = entry_i;
      bitcnt_d = 3'd7;
    end
  end

  always_comb begin
    step_d = step_q; mode_d = mode_q; acc_d = acc_q; bw_d = bw_q; lz_d = lz_q;
    loop_d = loop_q; hrd_d = hrd_q;
    status_d = status_q; profile_d = profile_q; flags_d = flags_q;
    width_d = width_q; height_d = height_q; fnum_d = fnum_q; poct_d = poct_q;
    sarn_d = sarn_q; sard_d = sard_q; tick_d = tick_q; scale_d = scale_q;
    reorder_d = reorder_q;
    fin_en = 1'b0;
    fin_v  = '0;
    nxt    = ST_DONE;
    nbits  = 6'd0;
    acc_nx = {acc_q[ACC_W-2:0], bit_v};
    bw_nx  = bw_q - 6'd1;
    base   = (mode_q == RD_FIXED) ? '0 : ((VAL_W'(1) << lz_q) - VAL_W'(1));
    loop_in = loop_q;

    if (do_feed && step_q != ST_DONE) begin
      if (mode_q == RD_PREFIX) begin
        if (!bit_v && !final_bit && (lz_q < LZ_W'(LZ_MAX))) begin
          lz_d = lz_q + 1'b1;
        end else if (lz_q == '0) begin
          fin_en = 1'b1;
        end else begin
          mode_d = RD_SUFFIX;
          bw_d   = lz_q;
          acc_d  = '0;
        end
      end else if (bw_nx == 6'd0) begin
        fin_en = 1'b1;
        fin_v  = base + VAL_W'(acc_nx);
      end else begin
        acc_d = acc_nx;
        bw_d  = bw_nx;
      end
    end

    if (do_drain) begin
      if ((step_q == ST_BRV || step_q == ST_CPBV || step_q == ST_CBR) &&
          (loop_q > LOOP_W'(1))) begin
        loop_in = LOOP_W'(1);
      end
      loop_d = loop_in;
      fin_en = 1'b1;
      fin_v  = (mode_q == RD_PREFIX) ? base : base + (VAL_W'(acc_q) << bw_q);
    end

    loop_dec = loop_in - LOOP_W'(1);

    if (fin_en) begin
      case (step_q)
        ST_PROFILE: begin profile_d = fin_v[7:0]; nxt = ST_SKIP16; end
        ST_SKIP16: nxt = ST_SPSID;
        ST_SPSID: begin
          if (fin_v >= VAL_W'(MAX_SPS_ID)) begin
            status_d = STAT_SPS_ID;
            nxt = ST_DONE;
          end else begin
            nxt = (profile_q >= PROFILE_HIGH) ? ST_CHROMA : ST_FRAMENUM;
          end
        end
        ST_CHROMA: nxt = (fin_v == VAL_W'(3)) ? ST_RESID : ST_DEPTHL;
        ST_RESID: nxt = ST_DEPTHL;
        ST_DEPTHL: nxt = ST_DEPTHC;
        ST_DEPTHC: nxt = ST_BYPASS;
        ST_BYPASS: begin
          if (fin_v != '0) flags_d[FL_BYPASS] = 1'b1;
          nxt = ST_SCALING;
        end
        ST_SCALING: nxt = ST_FRAMENUM;
        ST_FRAMENUM: begin
          fnum_d = (fin_v > VAL_W'(FNUM_MAX)) ? 4'(FNUM_MAX) : fin_v[3:0];
          nxt = ST_POCTYPE;
        end
        ST_POCTYPE: begin
          poct_d = (fin_v > VAL_W'(POCT_MAX)) ? 8'(POCT_MAX) : fin_v[7:0];
          if (fin_v == '0) nxt = ST_POCLSB;
          else if (fin_v == VAL_W'(1)) nxt = ST_DELTAZERO;
          else nxt = ST_NUMREF;
        end
        ST_POCLSB: nxt = ST_NUMREF;
        ST_DELTAZERO: nxt = ST_OFFNONREF;
        ST_OFFNONREF: nxt = ST_OFFTB;
        ST_OFFTB: nxt = ST_CYCLE;
        ST_CYCLE: begin
          loop_d = (fin_v > VAL_W'(MAX_POC_CYCLE)) ? LOOP_W'(MAX_POC_CYCLE) : fin_v;
          nxt = (fin_v != '0) ? ST_CYCLEOFF : ST_NUMREF;
        end
        ST_CYCLEOFF: begin
          loop_d = loop_dec;
          nxt = (loop_dec != '0) ? ST_CYCLEOFF : ST_NUMREF;
        end
        ST_NUMREF: nxt = ST_GAPS;
        ST_GAPS: nxt = ST_WIDTH;
        ST_WIDTH: begin
          width_d = (fin_v >= VAL_W'(SIZE_SAT_V)) ? 16'hFFFF :
                    {12'(fin_v[11:0] + 12'd1), 4'd0};
          nxt = ST_HEIGHT;
        end
        ST_HEIGHT: begin
          height_d = (fin_v >= VAL_W'(SIZE_SAT_V)) ? 16'hFFFF :
                     {12'(fin_v[11:0] + 12'd1), 4'd0};
          nxt = ST_MBSONLY;
        end
        ST_MBSONLY: begin
          if (fin_v != '0) begin
            flags_d[FL_MBS_ONLY] = 1'b1;
            nxt = ST_DIRECT;
          end else begin
            nxt = ST_MBAFF;
          end
        end
        ST_MBAFF: nxt = ST_DIRECT;
        ST_DIRECT: nxt = ST_CROP;
        ST_CROP: begin
          if (fin_v != '0) begin
            flags_d[FL_CROP] = 1'b1;
            loop_d = LOOP_W'(4);
            nxt = ST_CROPVAL;
          end else begin
            nxt = ST_VUI;
          end
        end
        ST_CROPVAL: begin
          loop_d = loop_dec;
          nxt = (loop_dec != '0) ? ST_CROPVAL : ST_VUI;
        end
        ST_VUI: begin
          if (fin_v != '0) begin
            flags_d[FL_VUI] = 1'b1;
            nxt = ST_ASPFLAG;
          end else begin
            nxt = ST_DONE;
          end
        end
        ST_ASPFLAG: nxt = (fin_v != '0) ? ST_ASPIDC : ST_OVERSCAN;
        ST_ASPIDC: begin
          nxt = ST_OVERSCAN;
          if (fin_v < VAL_W'(SAR_ENTRIES)) begin
            sarn_d = 16'(sar_num(fin_v[4:0]));
            sard_d = 16'(sar_den(fin_v[4:0]));
          end else if (fin_v == VAL_W'(SAR_ESCAPE)) begin
            nxt = ST_SARNUM;
          end
        end
        ST_SARNUM: begin sarn_d = fin_v[15:0]; nxt = ST_SARDEN; end
        ST_SARDEN: begin sard_d = fin_v[15:0]; nxt = ST_OVERSCAN; end
        ST_OVERSCAN: nxt = (fin_v != '0) ? ST_OVERAPP : ST_VIDSIG;
        ST_OVERAPP: nxt = ST_VIDSIG;
        ST_VIDSIG: nxt = (fin_v != '0) ? ST_VIDFMT : ST_CHROMALOC;
        ST_VIDFMT: nxt = ST_COLDESC;
        ST_COLDESC: nxt = (fin_v != '0) ? ST_COLOURS : ST_CHROMALOC;
        ST_COLOURS: nxt = ST_CHROMALOC;
        ST_CHROMALOC: begin
          if (fin_v != '0) begin
            loop_d = LOOP_W'(2);
            nxt = ST_CHROMALOCVAL;
          end else begin
            nxt = ST_TIMING;
          end
        end
        ST_CHROMALOCVAL: begin
          loop_d = loop_dec;
          nxt = (loop_dec != '0) ? ST_CHROMALOCVAL : ST_TIMING;
        end
        ST_TIMING: begin
          if (fin_v != '0) begin
            flags_d[FL_TIMING] = 1'b1;
            nxt = ST_TICK;
          end else begin
            nxt = ST_NALHRD;
          end
        end
        ST_TICK: begin tick_d = fin_v[31:0]; nxt = ST_SCALE; end
        ST_SCALE: begin scale_d = fin_v[31:0]; nxt = ST_FIXED; end
        ST_FIXED: begin
          if (fin_v != '0) flags_d[FL_FIXED] = 1'b1;
          nxt = ST_NALHRD;
        end
        ST_NALHRD: begin
          if (fin_v != '0) begin
            hrd_d[0] = 1'b1;
            nxt = ST_CPBCNT;
          end else begin
            nxt = ST_VCLHRD;
          end
        end
        ST_CPBCNT: begin loop_d = fin_v + LOOP_W'(1); nxt = ST_SCALES; end
        ST_SCALES: nxt = ST_BRV;
        ST_BRV: nxt = ST_CPBV;
        ST_CPBV: nxt = ST_CBR;
        ST_CBR: begin
          loop_d = loop_dec;
          nxt = (loop_dec != '0) ? ST_BRV : ST_DELAYS;
        end
        ST_DELAYS: nxt = hrd_q[1] ? ST_LOWDELAY : ST_VCLHRD;
        ST_VCLHRD: begin
          if (fin_v != '0) begin
            hrd_d[1] = 1'b1;
            nxt = ST_CPBCNT;
          end else begin
            nxt = hrd_q[0] ? ST_LOWDELAY : ST_PICSTRUCT;
          end
        end
        ST_LOWDELAY: nxt = ST_PICSTRUCT;
        ST_PICSTRUCT: nxt = ST_RESTRICT;
        ST_RESTRICT: begin
          if (fin_v != '0) begin
            flags_d[FL_RESTRICT] = 1'b1;
            nxt = ST_MVBOUND;
          end else begin
            nxt = ST_DONE;
          end
        end
        ST_MVBOUND: begin loop_d = LOOP_W'(4); nxt = ST_RESTRVAL; end
        ST_RESTRVAL: begin
          loop_d = loop_dec;
          nxt = (loop_dec != '0) ? ST_RESTRVAL : ST_REORDER;
        end
        ST_REORDER: begin
          if (fin_v > VAL_W'(REORDER_MAX)) status_d = STAT_REORDER;
          else reorder_d = fin_v[4:0];
          nxt = ST_DONE;
        end
        default: nxt = ST_DONE;
      endcase
      nbits  = step_bits(nxt);
      step_d = nxt;
      acc_d  = '0;
      lz_d   = '0;
      bw_d   = nbits;
      mode_d = (nbits == 6'd0) ? RD_PREFIX : RD_FIXED;
    end

    if (do_emit) begin
      step_d = ST_PROFILE; mode_d = RD_FIXED; acc_d = '0;
      bw_d = step_bits(ST_PROFILE); lz_d = '0; loop_d = '0; hrd_d = '0;
      status_d = STAT_OK; profile_d = '0; flags_d = '0; width_d = '0;
      height_d = '0; fnum_d = '0; poct_d = '0; sarn_d = '0; sard_d = '0;
      tick_d = '0; scale_d = '0; reorder_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      bitcnt_q <= 3'd0;
      step_q <= ST_PROFILE;
      mode_q <= RD_FIXED;
      acc_q <= '0;
      bw_q <= step_bits(ST_PROFILE);
      lz_q <= '0;
      loop_q <= '0;
      hrd_q <= '0;
      status_q <= STAT_OK;
      profile_q <= '0;
      flags_q <= '0;
      width_q <= '0;
      height_q <= '0;
      fnum_q <= '0;
      poct_q <= '0;
      sarn_q <= '0;
      sard_q <= '0;
      tick_q <= '0;
      scale_q <= '0;
      reorder_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bitcnt_q <= bitcnt_d;
      step_q <= step_d;
      mode_q <= mode_d;
      acc_q <= acc_d;
      bw_q <= bw_d;
      lz_q <= lz_d;
      loop_q <= loop_d;
      hrd_q <= hrd_d;
      status_q <= status_d;
      profile_q <= profile_d;
      flags_q <= flags_d;
      width_q <= width_d;
      height_q <= height_d;
      fnum_q <= fnum_d;
      poct_q <= poct_d;
      sarn_q <= sarn_d;
      sard_q <= sard_d;
      tick_q <= tick_d;
      scale_q <= scale_d;
      reorder_q <= reorder_d;
      out_valid_q <= do_emit || (out_valid_q && !res_out.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (do_emit) begin
      res_out.parse_status     <= status_q;
      res_out.profile_code     <= profile_q;
      res_out.flag_bits        <= flags_q;
      res_out.width_pixels     <= width_q;
      res_out.height_pixels    <= height_q;
      res_out.frame_num_log2   <= fnum_q;
      res_out.order_count_type <= poct_q;
      res_out.aspect_num       <= sarn_q;
      res_out.aspect_den       <= sard_q;
      res_out.tick_units       <= tick_q;
      res_out.clock_scale      <= scale_q;
      res_out.reorder_frames   <= reorder_q;
    end
  end

  assign res_out.valid = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/h264sps_header_parser.sv
// ----------------------------------------------------------------------------
// h264_sps_header_parser
// Parses an H.264 sequence parameter set payload and reports its key fields.
//
//   Channel   Direction  Transaction
//   sps_in    in         one raw payload byte, is_last on the final byte
//   res_out   out        one parse result for each parameter set
//
// The bit-serial syntax walker takes one bit a cycle, and waits between bytes
// while the queue is empty. After the final byte the walker closes the open
// syntax elements, one element a cycle.
// A four-entry queue decouples byte intake from the walker, and a held
// result does not stop the next payload from being parsed.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_sps_header_parser
  import h264sps_pkg::*;
#(
  parameter int unsigned MAX_POC_CYCLE = 256,
  parameter int unsigned MAX_SPS_ID    = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  h264sps_in_if.sink    sps_in,
  h264sps_out_if.source res_out
);

  logic     push, pop;
  entry_t   push_entry, pop_entry;
  fifo_st_t fifo_st;

  h264sps_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sps_in  (sps_in),
    .full_i  (fifo_st.full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  h264sps_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (fifo_st)
  );

  h264sps_back #(
    .MAX_POC_CYCLE (MAX_POC_CYCLE),
    .MAX_SPS_ID    (MAX_SPS_ID)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .entry_i   (pop_entry),
    .fifo_st_i (fifo_st),
    .pop_o     (pop),
    .res_out   (res_out)
  );

  a_queue_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_st.empty && fifo_st.full))
    else $error("queue reports empty and full together");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_st.empty)
    else $error("walker pops an empty queue");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid |-> (res_out.parse_status != 2'd3))
    else $error("undefined parse status");

  a_reorder_abort : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && res_out.parse_status == STAT_REORDER) |->
      (res_out.reorder_frames == 5'd0))
    else $error("reorder count kept after an aborted parse");

  a_fnum_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid |-> (res_out.frame_num_log2 <= 4'd12))
    else $error("frame number width above its clamp");

endmodule

`default_nettype wire

// File: verif/h264_sps_header_parser_tb.sv
// ----------------------------------------------------------------------------
// h264_sps_header_parser_tb
// Self-checking testbench of the SPS header parser. SPS payloads are built
// from the syntax with random content, along with noise and truncated
// payloads. Emulation-prevention bytes are inserted, and the bytes are sent
// with random gaps while the result side stalls at random. A bit-serial
// predictor computes the expected result of each payload, and every result
// transaction is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_sps_header_parser_tb;
  import h264sps_pkg::*;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } byte_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  profile;
    logic [6:0]  flags;
    logic [15:0] width;
    logic [15:0] height;
    logic [3:0]  fnum;
    logic [7:0]  poct;
    logic [15:0] sar_n;
    logic [15:0] sar_d;
    logic [31:0] tick;
    logic [31:0] scale;
    logic [4:0]  reorder;
  } sps_result_t;

  localparam longint unsigned MAX_SPS_ID_TB = 32;

  logic clk_i;
  logic rst_ni;

  h264sps_in_if  sps_in ();
  h264sps_out_if res_out ();

  h264_sps_header_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sps_in (sps_in.sink),
    .res_out(res_out.source)
  );

  byte_item_t  byte_q[$];
  sps_result_t sps_result_q[$];
  logic        bit_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned payloads_sent;
  int unsigned in_gap;
  int unsigned out_hold;
  bit          in_burst;

  // Predictor state.
  step_e           p_step;
  rd_e             p_mode;
  logic [31:0]     p_acc;
  int unsigned     p_want;
  int unsigned     p_lz;
  longint unsigned p_loop;
  logic [1:0]      p_hrd;
  int unsigned     p_zeros;
  sps_result_t     p_res;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned elem_len(step_e s);
    case (s)
      ST_PROFILE, ST_ASPIDC, ST_SCALES:        return 8;
      ST_SKIP16, ST_SARNUM, ST_SARDEN:         return 16;
      ST_VIDFMT:                               return 4;
      ST_COLOURS:                              return 24;
      ST_TICK, ST_SCALE:                       return 32;
      ST_DELAYS:                               return 20;
      ST_SPSID, ST_CHROMA, ST_DEPTHL, ST_DEPTHC, ST_FRAMENUM, ST_POCTYPE,
      ST_POCLSB, ST_OFFNONREF, ST_OFFTB, ST_CYCLE, ST_CYCLEOFF, ST_NUMREF,
      ST_WIDTH, ST_HEIGHT, ST_CROPVAL, ST_CHROMALOCVAL, ST_CPBCNT, ST_BRV,
      ST_CPBV, ST_RESTRVAL, ST_REORDER, ST_DONE: return 0;
      default:                                 return 1;
    endcase
  endfunction

  function automatic logic [15:0] size_px(longint unsigned v);
    longint unsigned p;
    p = (v + 1) * 16;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  task automatic begin_elem(step_e s);
    p_step = s;
    p_acc  = '0;
    p_lz   = 0;
    p_want = elem_len(s);
    p_mode = (p_want == 0) ? RD_PREFIX : RD_FIXED;
  endtask

  task automatic reset_parse();
    p_zeros = 0;
    p_loop  = 0;
    p_hrd   = '0;
    p_res   = '{default: '0};
    begin_elem(ST_PROFILE);
  endtask

  function automatic longint unsigned code_base();
    return (p_mode == RD_FIXED) ? 64'd0 : ((64'd1 << p_lz) - 64'd1);
  endfunction

  task automatic close_elem(longint unsigned v);
    case (p_step)
      ST_PROFILE: begin
        p_res.profile = v[7:0];
        begin_elem(ST_SKIP16);
      end
      ST_SKIP16: begin_elem(ST_SPSID);
      ST_SPSID: begin
        if (v >= MAX_SPS_ID_TB) begin
          p_res.status = STAT_SPS_ID;
          begin_elem(ST_DONE);
        end else begin
          begin_elem(p_res.profile >= PROFILE_HIGH ? ST_CHROMA : ST_FRAMENUM);
        end
      end
      ST_CHROMA: begin_elem(v == 3 ? ST_RESID : ST_DEPTHL);
      ST_RESID: begin_elem(ST_DEPTHL);
      ST_DEPTHL: begin_elem(ST_DEPTHC);
      ST_DEPTHC: begin_elem(ST_BYPASS);
      ST_BYPASS: begin
        if (v != 0) p_res.flags[FL_BYPASS] = 1'b1;
        begin_elem(ST_SCALING);
      end
      ST_SCALING: begin_elem(ST_FRAMENUM);
      ST_FRAMENUM: begin
        p_res.fnum = (v > 12) ? 4'd12 : v[3:0];
        begin_elem(ST_POCTYPE);
      end
      ST_POCTYPE: begin
        p_res.poct = (v > 255) ? 8'hFF : v[7:0];
        begin_elem(v == 0 ? ST_POCLSB : (v == 1 ? ST_DELTAZERO : ST_NUMREF));
      end
      ST_POCLSB: begin_elem(ST_NUMREF);
      ST_DELTAZERO: begin_elem(ST_OFFNONREF);
      ST_OFFNONREF: begin_elem(ST_OFFTB);
      ST_OFFTB: begin_elem(ST_CYCLE);
      ST_CYCLE: begin
        p_loop = (v > 256) ? 64'd256 : v;
        begin_elem(p_loop != 0 ? ST_CYCLEOFF : ST_NUMREF);
      end
      ST_CYCLEOFF: begin
        p_loop--;
        begin_elem(p_loop != 0 ? ST_CYCLEOFF : ST_NUMREF);
      end
      ST_NUMREF: begin_elem(ST_GAPS);
      ST_GAPS: begin_elem(ST_WIDTH);
      ST_WIDTH: begin
        p_res.width = size_px(v);
        begin_elem(ST_HEIGHT);
      end
      ST_HEIGHT: begin
        p_res.height = size_px(v);
        begin_elem(ST_MBSONLY);
      end
      ST_MBSONLY: begin
        if (v != 0) begin
          p_res.flags[FL_MBS_ONLY] = 1'b1;
          begin_elem(ST_DIRECT);
        end else begin
          begin_elem(ST_MBAFF);
        end
      end
      ST_MBAFF: begin_elem(ST_DIRECT);
      ST_DIRECT: begin_elem(ST_CROP);
      ST_CROP: begin
        if (v != 0) begin
          p_res.flags[FL_CROP] = 1'b1;
          p_loop = 4;
          begin_elem(ST_CROPVAL);
        end else begin
          begin_elem(ST_VUI);
        end
      end
      ST_CROPVAL: begin
        p_loop--;
        begin_elem(p_loop != 0 ? ST_CROPVAL : ST_VUI);
      end
      ST_VUI: begin
        if (v != 0) begin
          p_res.flags[FL_VUI] = 1'b1;
          begin_elem(ST_ASPFLAG);
        end else begin
          begin_elem(ST_DONE);
        end
      end
      ST_ASPFLAG: begin_elem(v != 0 ? ST_ASPIDC : ST_OVERSCAN);
      ST_ASPIDC: begin
        if (v < 17) begin
          p_res.sar_n = sar_tab_num(v[4:0]);
          p_res.sar_d = sar_tab_den(v[4:0]);
          begin_elem(ST_OVERSCAN);
        end else if (v == SAR_ESCAPE) begin
          begin_elem(ST_SARNUM);
        end else begin
          begin_elem(ST_OVERSCAN);
        end
      end
      ST_SARNUM: begin
        p_res.sar_n = v[15:0];
        begin_elem(ST_SARDEN);
      end
      ST_SARDEN: begin
        p_res.sar_d = v[15:0];
        begin_elem(ST_OVERSCAN);
      end
      ST_OVERSCAN: begin_elem(v != 0 ? ST_OVERAPP : ST_VIDSIG);
      ST_OVERAPP: begin_elem(ST_VIDSIG);
      ST_VIDSIG: begin_elem(v != 0 ? ST_VIDFMT : ST_CHROMALOC);
      ST_VIDFMT: begin_elem(ST_COLDESC);
      ST_COLDESC: begin_elem(v != 0 ? ST_COLOURS : ST_CHROMALOC);
      ST_COLOURS: begin_elem(ST_CHROMALOC);
      ST_CHROMALOC: begin
        if (v != 0) begin
          p_loop = 2;
          begin_elem(ST_CHROMALOCVAL);
        end else begin
          begin_elem(ST_TIMING);
        end
      end
      ST_CHROMALOCVAL: begin
        p_loop--;
        begin_elem(p_loop != 0 ? ST_CHROMALOCVAL : ST_TIMING);
      end
      ST_TIMING: begin
        if (v != 0) begin
          p_res.flags[FL_TIMING] = 1'b1;
          begin_elem(ST_TICK);
        end else begin
          begin_elem(ST_NALHRD);
        end
      end
      ST_TICK: begin
        p_res.tick = v[31:0];
        begin_elem(ST_SCALE);
      end
      ST_SCALE: begin
        p_res.scale = v[31:0];
        begin_elem(ST_FIXED);
      end
      ST_FIXED: begin
        if (v != 0) p_res.flags[FL_FIXED] = 1'b1;
        begin_elem(ST_NALHRD);
      end
      ST_NALHRD: begin
        if (v != 0) begin
          p_hrd[0] = 1'b1;
          begin_elem(ST_CPBCNT);
        end else begin
          begin_elem(ST_VCLHRD);
        end
      end
      ST_CPBCNT: begin
        p_loop = v + 1;
        begin_elem(ST_SCALES);
      end
      ST_SCALES: begin_elem(ST_BRV);
      ST_BRV: begin_elem(ST_CPBV);
      ST_CPBV: begin_elem(ST_CBR);
      ST_CBR: begin
        p_loop--;
        begin_elem(p_loop != 0 ? ST_BRV : ST_DELAYS);
      end
      ST_DELAYS: begin_elem(p_hrd[1] ? ST_LOWDELAY : ST_VCLHRD);
      ST_VCLHRD: begin
        if (v != 0) begin
          p_hrd[1] = 1'b1;
          begin_elem(ST_CPBCNT);
        end else begin
          begin_elem(p_hrd[0] ? ST_LOWDELAY : ST_PICSTRUCT);
        end
      end
      ST_LOWDELAY: begin_elem(ST_PICSTRUCT);
      ST_PICSTRUCT: begin_elem(ST_RESTRICT);
      ST_RESTRICT: begin
        if (v != 0) begin
          p_res.flags[FL_RESTRICT] = 1'b1;
          begin_elem(ST_MVBOUND);
        end else begin
          begin_elem(ST_DONE);
        end
      end
      ST_MVBOUND: begin
        p_loop = 4;
        begin_elem(ST_RESTRVAL);
      end
      ST_RESTRVAL: begin
        p_loop--;
        begin_elem(p_loop != 0 ? ST_RESTRVAL : ST_REORDER);
      end
      ST_REORDER: begin
        if (v > REORDER_MAX) p_res.status = STAT_REORDER;
        else p_res.reorder = v[4:0];
        begin_elem(ST_DONE);
      end
      default: begin_elem(ST_DONE);
    endcase
  endtask

  function automatic logic [15:0] sar_tab_num(logic [4:0] i);
    logic [7:0] t[17];
    t = '{0, 1, 12, 10, 16, 40, 24, 20, 32, 80, 18, 15, 64, 160, 4, 3, 2};
    return {8'd0, t[i]};
  endfunction

  function automatic logic [15:0] sar_tab_den(logic [4:0] i);
    logic [7:0] t[17];
    t = '{0, 1, 11, 11, 11, 33, 11, 11, 11, 33, 11, 11, 33, 99, 3, 2, 1};
    return {8'd0, t[i]};
  endfunction

  task automatic parse_bit(logic b, bit final_bit);
    if (p_step >= ST_DONE) return;
    if (p_mode == RD_PREFIX) begin
      if (b == 1'b0 && !final_bit && p_lz < LZ_MAX) begin
        p_lz++;
        return;
      end
      if (p_lz == 0) begin
        close_elem(0);
        return;
      end
      p_mode = RD_SUFFIX;
      p_want = p_lz;
      p_acc  = '0;
      return;
    end
    p_acc = {p_acc[30:0], b};
    if (p_want > 0) p_want--;
    if (p_want == 0) close_elem(code_base() + p_acc);
  endtask

  task automatic predict_byte(byte_item_t it);
    longint unsigned v;
    if (p_zeros >= 2 && it.data == EPB_CODE && !it.last) begin
      p_zeros = 0;
      return;
    end
    for (int i = 7; i >= 0; i--) parse_bit(it.data[i], it.last && i == 0);
    p_zeros = (it.data == 8'd0) ? ((p_zeros >= 2) ? 2 : p_zeros + 1) : 0;
    if (!it.last) return;
    while (p_step < ST_DONE) begin
      if ((p_step == ST_BRV || p_step == ST_CPBV || p_step == ST_CBR) && p_loop > 1)
        p_loop = 1;
      if (p_mode == RD_PREFIX) v = code_base();
      else v = code_base() + (64'(p_acc) << (p_want & 63));
      close_elem(v);
    end
    sps_result_q.push_back(p_res);
    reset_parse();
  endtask

  // Payload construction.
  task automatic put_bits(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) bit_q.push_back(v[i]);
  endtask

  task automatic put_ue(longint unsigned v);
    longint unsigned x;
    int k;
    x = v + 1;
    k = 0;
    for (int i = 0; i < 64; i++) if (x[i]) k = i;
    put_bits(0, k);
    put_bits(x, k + 1);
  endtask

  function automatic longint unsigned rand_ue();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 4);
    if (r < 92) return $urandom_range(0, 300);
    if (r < 98) return $urandom;
    return 64'h1_FFFF_FFFE;
  endfunction

  task automatic put_hrd(bit deep);
    int unsigned n;
    n = deep ? $urandom_range(0, 31) : $urandom_range(0, 2);
    put_ue(n);
    put_bits($urandom, 8);
    for (int unsigned i = 0; i <= n; i++) begin
      put_ue(rand_ue());
      put_ue(rand_ue());
      put_bits($urandom, 1);
    end
    put_bits($urandom, 20);
  endtask

  task automatic push_byte(logic [7:0] d, bit last, inout int zr);
    byte_q.push_back('{last: last, data: d});
    zr = (d == 8'd0) ? zr + 1 : 0;
  endtask

  // Kinds: 0 random syntax, 1 high profile with chroma 3, 2 sps id out of range,
  // 3 reorder over limit, 4 maximal exp-Golomb codes, 5 explicit aspect,
  // 6 reserved aspect index, 7 long POC cycle, 8 both HRD blocks,
  // 9 single byte, 10 final 0x03 after zeros, 11 noise, 12 zero bytes.
  task automatic gen_sps(int kind);
    logic [7:0]      bytes[$];
    longint unsigned poct;
    logic [7:0]      prof, idc;
    bit              vui, nal, vcl;
    int              zr, n, cut;
    bit_q.delete();
    zr = 0;
    if (kind == 9) begin
      push_byte(8'($urandom), 1'b1, zr);
      payloads_sent++;
      return;
    end
    if (kind == 11 || kind == 12) begin
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
        if (kind == 12) push_byte(8'd0, i == n - 1, zr);
        else if ($urandom_range(0, 3) == 0) push_byte(EPB_CODE, i == n - 1, zr);
        else push_byte($urandom_range(0, 2) == 0 ? 8'd0 : 8'($urandom), i == n - 1, zr);
      end
      payloads_sent++;
      return;
    end
    prof = (kind == 1) ? 8'd100 : ($urandom_range(0, 2) == 0 ? 8'd66 :
           ($urandom_range(0, 1) ? 8'd100 : 8'($urandom)));
    put_bits(prof, 8);
    put_bits($urandom, 16);
    put_ue(kind == 2 ? 64'd32 + $urandom_range(0, 40) : $urandom_range(0, 31));
    if (prof >= 100) begin
      n = (kind == 1) ? 3 : $urandom_range(0, 3);
      put_ue(n);
      if (n == 3) put_bits($urandom, 1);
      put_ue(rand_ue());
      put_ue(rand_ue());
      put_bits($urandom, 2);
    end
    put_ue(kind == 4 ? 64'h1_FFFF_FFFE : rand_ue());
    poct = (kind == 7) ? 1 : ($urandom_range(0, 9) == 0 ? rand_ue() : $urandom_range(0, 2));
    put_ue(poct);
    if (poct == 0) begin
      put_ue(rand_ue());
    end else if (poct == 1) begin
      put_bits($urandom, 1);
      put_ue(rand_ue());
      put_ue(rand_ue());
      n = (kind == 7) ? 256 + $urandom_range(0, 1) : $urandom_range(0, 4);
      put_ue(n);
      for (int i = 0; i < ((n > 256) ? 256 : n); i++) put_ue($urandom_range(0, 3));
    end
    put_ue(rand_ue());
    put_bits($urandom, 1);
    put_ue(kind == 4 ? 64'h1_FFFF_FFFE : $urandom_range(0, 200));
    put_ue(kind == 4 ? 64'd4095 : $urandom_range(0, 200));
    n = $urandom_range(0, 1);
    put_bits(n, 1);
    if (n == 0) put_bits($urandom, 1);
    put_bits($urandom, 1);
    n = $urandom_range(0, 1);
    put_bits(n, 1);
    if (n) for (int i = 0; i < 4; i++) put_ue(rand_ue());
    vui = (kind >= 3 && kind <= 8) ? 1'b1 : ($urandom_range(0, 3) != 0);
    put_bits(vui, 1);
    if (vui) begin
      n = (kind == 5 || kind == 6) ? 1 : $urandom_range(0, 1);
      put_bits(n, 1);
      if (n) begin
        idc = (kind == 5) ? 8'd255 : (kind == 6) ? 8'($urandom_range(17, 254)) :
              ($urandom_range(0, 3) == 0 ? 8'd255 : 8'($urandom_range(0, 16)));
        put_bits(idc, 8);
        if (idc == 8'd255) put_bits($urandom, 32);
      end
      n = $urandom_range(0, 1);
      put_bits(n, 1);
      if (n) put_bits($urandom, 1);
      n = $urandom_range(0, 1);
      put_bits(n, 1);
      if (n) begin
        put_bits($urandom, 4);
        n = $urandom_range(0, 1);
        put_bits(n, 1);
        if (n) put_bits($urandom, 24);
      end
      n = $urandom_range(0, 1);
      put_bits(n, 1);
      if (n) begin
        put_ue(rand_ue());
        put_ue(rand_ue());
      end
      n = $urandom_range(0, 2) != 0;
      put_bits(n, 1);
      if (n) begin
        put_bits($urandom, 32);
        put_bits($urandom, 32);
        put_bits($urandom, 1);
      end
      nal = (kind == 8) ? 1'b1 : ($urandom_range(0, 3) == 0);
      put_bits(nal, 1);
      if (nal) put_hrd(kind == 8);
      vcl = (kind == 8) ? 1'b1 : ($urandom_range(0, 3) == 0);
      put_bits(vcl, 1);
      if (vcl) put_hrd(kind == 8);
      if (nal || vcl) put_bits($urandom, 1);
      put_bits($urandom, 1);
      n = (kind == 3) ? 1 : $urandom_range(0, 1);
      put_bits(n, 1);
      if (n) begin
        put_bits($urandom, 1);
        for (int i = 0; i < 4; i++) put_ue(rand_ue());
        put_ue(kind == 3 ? 64'd17 + $urandom_range(0, 100) :
               ($urandom_range(0, 5) == 0 ? rand_ue() : $urandom_range(0, 16)));
        put_ue(rand_ue());
      end
    end
    put_bits(1, 1);
    while (bit_q.size() % 8 != 0) bit_q.push_back(1'b0);
    while (bit_q.size() > 0) begin
      bytes.push_back('0);
      for (int i = 7; i >= 0; i--) bytes[$][i] = bit_q.pop_front();
    end
    if (kind == 0 && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, bytes.size());
      while (bytes.size() > cut) void'(bytes.pop_back());
    end
    for (int i = 0; i < bytes.size(); i++) begin
      if (zr >= 2 && bytes[i] <= 8'd3) push_byte(EPB_CODE, 1'b0, zr);
      push_byte(bytes[i], (kind != 10) && (i == bytes.size() - 1), zr);
    end
    if (kind == 10) begin
      push_byte(8'd0, 1'b0, zr);
      push_byte(8'd0, 1'b0, zr);
      push_byte(EPB_CODE, 1'b1, zr);
    end
    payloads_sent++;
  endtask

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    byte_item_t it;
    if (!rst_ni) begin
      sps_in.valid        <= 1'b0;
      sps_in.payload_byte <= '0;
      sps_in.is_last      <= 1'b0;
      in_gap = 0;
      in_burst = 1'b0;
    end else begin
      if (sps_in.valid && sps_in.ready) begin
        predict_byte('{last: sps_in.is_last, data: sps_in.payload_byte});
      end
      if (!(sps_in.valid && !sps_in.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          sps_in.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          it = byte_q.pop_front();
          sps_in.valid        <= 1'b1;
          sps_in.payload_byte <= it.data;
          sps_in.is_last      <= it.last;
          if ($urandom_range(0, 31) == 0) in_burst = ~in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 9);
        end else begin
          sps_in.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    sps_result_t e;
    sps_result_t a;
    if (!rst_ni) begin
      res_out.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        results_seen++;
        a = '{res_out.parse_status, res_out.profile_code, res_out.flag_bits,
              res_out.width_pixels, res_out.height_pixels, res_out.frame_num_log2,
              res_out.order_count_type, res_out.aspect_num, res_out.aspect_den,
              res_out.tick_units, res_out.clock_scale, res_out.reorder_frames};
        if (sps_result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transaction: %p", a);
        end else begin
          e = sps_result_q.pop_front();
          if (e.status != a.status || e.profile != a.profile || e.flags != a.flags ||
              e.width != a.width || e.height != a.height || e.fnum != a.fnum ||
              e.poct != a.poct || e.sar_n != a.sar_n || e.sar_d != a.sar_d ||
              e.tick != a.tick || e.scale != a.scale || e.reorder != a.reorder) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result mismatch at %0t", $time);
              $display("  expected %p", e);
              $display("  actual   %p", a);
            end
          end
        end
        out_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end
      res_out.ready <= (out_hold == 0);
      if (out_hold > 0) out_hold--;
    end
  end

  initial begin
    #50_000_000;
    $display("FAIL h264_sps_header_parser");
    $finish;
  end

  initial begin
    int unsigned kind;
    mismatches    = 0;
    results_seen  = 0;
    payloads_sent = 0;
    reset_parse();
    rst_ni = 1'b0;
    for (int k = 1; k <= 12; k++) gen_sps(k);
    gen_sps(0);
    gen_sps(9);
    while (byte_q.size() < 1400) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) gen_sps(0);
      else if (kind < 90) gen_sps(11);
      else gen_sps($urandom_range(1, 12));
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (byte_q.size() == 0 && !sps_in.valid && sps_result_q.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d parameter sets, %0d results checked, %0d mismatches.",
             payloads_sent, results_seen, mismatches);
    if (mismatches == 0 && sps_result_q.size() == 0) begin
      $display("PASS h264_sps_header_parser");
    end else begin
      $display("FAIL h264_sps_header_parser");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: h264_sps_header_parser.f
hdl/h264sps_pkg.sv
hdl/h264sps_in_if.sv
hdl/h264sps_out_if.sv
hdl/h264sps_front.sv
hdl/h264sps_fifo.sv
hdl/h264sps_back.sv
hdl/h264sps_header_parser.sv
verif/h264_sps_header_parser_tb.sv
